// ===== rtl/tksd_pkg.sv =====
// Package for the terminal key sequence decoder.
// Key kind codes, character byte constants and the result record.
// No dependencies.
package tksd_pkg;

	localparam logic [3:0] KIND_NONE    = 4'd0;
	localparam logic [3:0] KIND_REGULAR = 4'd1;
	localparam logic [3:0] KIND_UNKNOWN = 4'd2;
	localparam logic [3:0] KIND_UP      = 4'd3;
	localparam logic [3:0] KIND_DOWN    = 4'd4;
	localparam logic [3:0] KIND_RIGHT   = 4'd5;
	localparam logic [3:0] KIND_LEFT    = 4'd6;
	localparam logic [3:0] KIND_HOME    = 4'd7;
	localparam logic [3:0] KIND_END     = 4'd8;
	localparam logic [3:0] KIND_INSERT  = 4'd9;
	localparam logic [3:0] KIND_DELETE  = 4'd10;
	localparam logic [3:0] KIND_PGUP    = 4'd11;
	localparam logic [3:0] KIND_PGDN    = 4'd12;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRKT = 8'h5B;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
	localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic       last;
	} result_t;

endpackage

// ===== rtl/terminal_key_sequence_decoder_core.sv =====
// A result is registered into the output queue when its input transaction is accepted.
// Throughput: one input per cycle while in_stall is low; an ESC followed by a
// plain byte yields two results, which leave a four-entry output queue one by one.
// Input stalls while the queue holds more than two results.
// Reset (arst_n low, asynchronous): parser idle, queue empty, raw mode off.
// Depends on tksd_pkg.
module terminal_key_sequence_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_byte,
	input  logic       read_error,
	input  logic [1:0] bytes_behind,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] key_kind,
	output logic [7:0] char_byte0,
	output logic [7:0] char_byte1,
	output logic [7:0] char_byte2,
	output logic [7:0] char_byte3,
	output logic       last_result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_CSI,
		PH_CSIP,
		PH_UTF8,
		PH_UTF8_BAD
	} phase_t;

	typedef struct packed {
		logic                 emit;
		tksd_pkg::result_t    res;
		phase_t               phase;
		logic [2:0]           need;
	} fresh_t;

	function automatic tksd_pkg::result_t mk_res(input logic [3:0] kind, input logic [7:0] b0);
		tksd_pkg::result_t r;
		r      = '0;
		r.kind = kind;
		r.b0   = b0;
		return r;
	endfunction

	function automatic fresh_t fresh_decode(input logic [7:0] b, input logic err,
	                                        input logic [1:0] behind);
		fresh_t f;
		logic [2:0] need;
		f       = '0;
		f.phase = PH_IDLE;
		need    = 3'd4;
		if ((b & 8'hE0) == 8'hC0)
			need = 3'd2;
		else if ((b & 8'hF0) == 8'hE0)
			need = 3'd3;
		if (err) begin
			f.emit = 1'b1;
			f.res  = mk_res(tksd_pkg::KIND_NONE, 8'd0);
		end else if (!b[7]) begin
			if (b != tksd_pkg::CH_ESC || behind == 2'd0) begin
				f.emit = 1'b1;
				f.res  = mk_res(tksd_pkg::KIND_REGULAR, b);
			end else begin
				f.phase = PH_ESC;
			end
		end else if ({1'b0, behind} + 3'd1 < need) begin
			f.emit = 1'b1;
			f.res  = mk_res(tksd_pkg::KIND_UNKNOWN, 8'd0);
		end else begin
			f.phase = PH_UTF8;
			f.need  = need;
		end
		return f;
	endfunction

	logic       raw_q;
	phase_t     phase_q, phase_d;
	logic [7:0] csi_q;
	logic [7:0] ubytes_q [3];
	logic [2:0] need_q, need_d;
	logic [2:0] coll_q, coll_d;
	logic       load_lead, load_csi, load_ubyte;

	tksd_pkg::result_t r0, r1;
	logic [1:0]        n_res;
	fresh_t            fr;
	logic [2:0]        ncol;
	logic [7:0]        cc [4];

	tksd_pkg::result_t fifo_q [tksd_pkg::OUT_DEPTH];
	logic [tksd_pkg::PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [tksd_pkg::CNT_W-1:0] cnt_q;
	logic                       in_acc, out_acc;

	assign in_stall = cnt_q > tksd_pkg::CNT_W'(2);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = cnt_q != '0;
	assign out_acc  = out_valid && !out_stall;

	assign key_kind    = fifo_q[rd_ptr_q].kind;
	assign char_byte0  = fifo_q[rd_ptr_q].b0;
	assign char_byte1  = fifo_q[rd_ptr_q].b1;
	assign char_byte2  = fifo_q[rd_ptr_q].b2;
	assign char_byte3  = fifo_q[rd_ptr_q].b3;
	assign last_result = fifo_q[rd_ptr_q].last;

	always_comb begin
		r0         = '0;
		r1         = '0;
		n_res      = 2'd0;
		phase_d    = phase_q;
		need_d     = need_q;
		coll_d     = coll_q;
		load_lead  = 1'b0;
		load_csi   = 1'b0;
		load_ubyte = 1'b0;
		fr         = fresh_decode(key_byte, read_error, bytes_behind);
		ncol       = coll_q + 3'd1;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) == ncol - 3'd1)
				cc[i] = key_byte;
			else if (3'(i) < ncol - 3'd1 && i < 3)
				cc[i] = ubytes_q[i[1:0]];
			else
				cc[i] = 8'd0;
		end
		if (raw_q) begin
			case (phase_q)
				PH_ESC: begin
					phase_d = PH_IDLE;
					if (read_error) begin
						n_res = 2'd1;
						r0    = mk_res(tksd_pkg::KIND_NONE, 8'd0);
					end else if (key_byte != tksd_pkg::CH_LBRKT) begin
						fr    = fresh_decode(key_byte, 1'b0, bytes_behind);
						r0    = mk_res(tksd_pkg::KIND_REGULAR, tksd_pkg::CH_ESC);
						r1    = fr.res;
						n_res = fr.emit ? 2'd2 : 2'd1;
						phase_d = fr.phase;
						if (fr.phase == PH_UTF8) begin
							load_lead = 1'b1;
							need_d    = fr.need;
							coll_d    = 3'd1;
						end
					end else if (bytes_behind == 2'd0) begin
						n_res = 2'd1;
						r0    = mk_res(tksd_pkg::KIND_UNKNOWN, 8'd0);
					end else begin
						phase_d = PH_CSI;
					end
				end
				PH_CSI: begin
					phase_d = PH_IDLE;
					n_res   = 2'd1;
					if (read_error)
						r0 = mk_res(tksd_pkg::KIND_NONE, 8'd0);
					else begin
						case (key_byte)
							"A":     r0 = mk_res(tksd_pkg::KIND_UP, 8'd0);
							"B":     r0 = mk_res(tksd_pkg::KIND_DOWN, 8'd0);
							"C":     r0 = mk_res(tksd_pkg::KIND_RIGHT, 8'd0);
							"D":     r0 = mk_res(tksd_pkg::KIND_LEFT, 8'd0);
							"H":     r0 = mk_res(tksd_pkg::KIND_HOME, 8'd0);
							"F":     r0 = mk_res(tksd_pkg::KIND_END, 8'd0);
							default: begin
								if (bytes_behind == 2'd0)
									r0 = mk_res(tksd_pkg::KIND_UNKNOWN, 8'd0);
								else begin
									n_res    = 2'd0;
									load_csi = 1'b1;
									phase_d  = PH_CSIP;
								end
							end
						endcase
					end
				end
				PH_CSIP: begin
					phase_d = PH_IDLE;
					n_res   = 2'd1;
					r0      = mk_res(tksd_pkg::KIND_UNKNOWN, 8'd0);
					if (read_error)
						r0 = mk_res(tksd_pkg::KIND_NONE, 8'd0);
					else if (key_byte == tksd_pkg::CH_TILDE) begin
						case (csi_q)
							"2":     r0 = mk_res(tksd_pkg::KIND_INSERT, 8'd0);
							"3":     r0 = mk_res(tksd_pkg::KIND_DELETE, 8'd0);
							"5":     r0 = mk_res(tksd_pkg::KIND_PGUP, 8'd0);
							"6":     r0 = mk_res(tksd_pkg::KIND_PGDN, 8'd0);
							default: r0 = mk_res(tksd_pkg::KIND_UNKNOWN, 8'd0);
						endcase
					end
				end
				PH_UTF8, PH_UTF8_BAD: begin
					if (read_error)
						phase_d = PH_UTF8_BAD;
					else
						load_ubyte = coll_q < 3'd3;
					coll_d = ncol;
					if (ncol >= need_q) begin
						n_res = 2'd1;
						if (phase_d == PH_UTF8_BAD)
							r0 = mk_res(tksd_pkg::KIND_UNKNOWN, 8'd0);
						else begin
							r0.kind = tksd_pkg::KIND_REGULAR;
							r0.b0   = cc[0];
							r0.b1   = cc[1];
							r0.b2   = cc[2];
							r0.b3   = cc[3];
						end
						phase_d = PH_IDLE;
						need_d  = 3'd0;
						coll_d  = 3'd0;
					end
				end
				default: begin
					r0      = fr.res;
					n_res   = fr.emit ? 2'd1 : 2'd0;
					phase_d = fr.phase;
					if (fr.phase == PH_UTF8) begin
						load_lead = 1'b1;
						need_d    = fr.need;
						coll_d    = 3'd1;
					end
				end
			endcase
		end
		if (n_res == 2'd1)
			r0.last = 1'b1;
		if (n_res == 2'd2)
			r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q   <= 1'b0;
			phase_q <= PH_IDLE;
			need_q  <= 3'd0;
			coll_q  <= 3'd0;
		end else begin
			if (cfg_we)
				raw_q <= cfg_wdata;
			if (in_acc) begin
				phase_q <= phase_d;
				need_q  <= need_d;
				coll_q  <= coll_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (load_csi)
				csi_q <= key_byte;
			if (load_lead)
				ubytes_q[0] <= key_byte;
			if (load_ubyte)
				ubytes_q[coll_q[1:0]] <= key_byte;
			if (n_res != 2'd0)
				fifo_q[wr_ptr_q] <= r0;
			if (n_res == 2'd2)
				fifo_q[wr_ptr_q + tksd_pkg::PTR_W'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (out_acc)
				rd_ptr_q <= rd_ptr_q + tksd_pkg::PTR_W'(1);
			if (in_acc)
				wr_ptr_q <= wr_ptr_q + tksd_pkg::PTR_W'(n_res);
			cnt_q <= cnt_q + (in_acc ? tksd_pkg::CNT_W'(n_res) : '0)
			               - (out_acc ? tksd_pkg::CNT_W'(1) : '0);
		end
	end

endmodule

// ===== rtl/tksd_checker.sv =====
// Port-level checker for the terminal key sequence decoder, with its bind.
// Depends on tksd_pkg and terminal_key_sequence_decoder_core.
module tksd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] key_kind,
	input logic [7:0] char_byte0,
	input logic [7:0] char_byte1,
	input logic [7:0] char_byte2,
	input logic [7:0] char_byte3,
	input logic       last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_kind) && $stable(last_result))
		else $error("stalled result changed");

	a_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_kind != tksd_pkg::KIND_REGULAR |->
		char_byte0 == 8'd0 && char_byte1 == 8'd0 && char_byte2 == 8'd0 && char_byte3 == 8'd0)
		else $error("non-character result carries bytes");

	a_none_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_kind == tksd_pkg::KIND_NONE |-> last_result)
		else $error("none result not final");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind terminal_key_sequence_decoder_core tksd_checker u_tksd_checker (.*);

// ===== tb/sv/terminal_key_sequence_decoder_core_tb.sv =====
// Self-checking testbench for terminal_key_sequence_decoder_core: directed and random key byte
// streams, a local decoder model predicting key events, random idling on both channels.
// Depends on tksd_pkg and the decoder core RTL.
`timescale 1ns / 1ps

module terminal_key_sequence_decoder_core_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 6;

	localparam logic [7:0] CSI_UP    = 8'h41;
	localparam logic [7:0] CSI_DOWN  = 8'h42;
	localparam logic [7:0] CSI_RIGHT = 8'h43;
	localparam logic [7:0] CSI_LEFT  = 8'h44;
	localparam logic [7:0] CSI_HOME  = 8'h48;
	localparam logic [7:0] CSI_END   = 8'h46;
	localparam logic [7:0] PARM_INS  = 8'h32;
	localparam logic [7:0] PARM_DEL  = 8'h33;
	localparam logic [7:0] PARM_PGUP = 8'h35;
	localparam logic [7:0] PARM_PGDN = 8'h36;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ESC, ST_CSI, ST_CSI_PARAM, ST_UTF8, ST_UTF8_BAD
	} parse_state_t;

	typedef struct packed {
		logic [7:0] b;
		logic       err;
		logic [1:0] behind;
	} key_input_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] key_byte = 8'h00;
	logic       read_error = 1'b0;
	logic [1:0] bytes_behind = 2'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] key_kind;
	logic [7:0] char_byte0;
	logic [7:0] char_byte1;
	logic [7:0] char_byte2;
	logic [7:0] char_byte3;
	logic       last_result;

	terminal_key_sequence_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_byte     (key_byte),
		.read_error   (read_error),
		.bytes_behind (bytes_behind),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_kind     (key_kind),
		.char_byte0   (char_byte0),
		.char_byte1   (char_byte1),
		.char_byte2   (char_byte2),
		.char_byte3   (char_byte3),
		.last_result  (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	key_input_t          pending_keys[$];
	tksd_pkg::result_t   key_events[$];
	parse_state_t        parse_state = ST_IDLE;
	logic [7:0]          csi_param = 8'h00;
	logic [7:0]          utf8_buf[3] = '{8'h00, 8'h00, 8'h00};
	logic [2:0]          utf8_need = 3'd0;
	logic [2:0]          utf8_count = 3'd0;
	logic                raw_mode = 1'b0;
	logic                quiet = 1'b0;
	int                  mismatches = 0;
	int                  events_seen = 0;
	int                  keys_queued = 0;
	int                  send_gap = 0;
	int                  stall_left = 0;
	int                  cycle_count = 0;

	logic [7:0] arrow_keys[6] = '{CSI_UP, CSI_DOWN, CSI_RIGHT, CSI_LEFT, CSI_HOME, CSI_END};
	logic [7:0] edit_params[4] = '{PARM_INS, PARM_DEL, PARM_PGUP, PARM_PGDN};

	function automatic void add_event(logic [3:0] kind, logic [7:0] c0, logic [7:0] c1,
		logic [7:0] c2, logic [7:0] c3);
		tksd_pkg::result_t r;
		r.kind = kind;
		r.b0 = c0;
		r.b1 = c1;
		r.b2 = c2;
		r.b3 = c3;
		r.last = 1'b0;
		key_events.insert(key_events.size(), r);
	endfunction

	function automatic void decode_fresh(logic [7:0] b, logic err, logic [1:0] behind);
		int need;
		parse_state = ST_IDLE;
		if (err) begin
			add_event(tksd_pkg::KIND_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
			return;
		end
		if (b < 8'h80) begin
			if (b != tksd_pkg::CH_ESC)
				add_event(tksd_pkg::KIND_REGULAR, b, 8'h00, 8'h00, 8'h00);
			else if (behind == 2'd0)
				add_event(tksd_pkg::KIND_REGULAR, tksd_pkg::CH_ESC, 8'h00, 8'h00, 8'h00);
			else
				parse_state = ST_ESC;
			return;
		end
		if ((b & 8'hE0) == 8'hC0)
			need = 2;
		else if ((b & 8'hF0) == 8'hE0)
			need = 3;
		else
			need = 4;
		if (int'(behind) + 1 < need) begin
			add_event(tksd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00);
			return;
		end
		utf8_buf[0] = b;
		utf8_need = 3'(need);
		utf8_count = 3'd1;
		parse_state = ST_UTF8;
	endfunction

	function automatic void decode_transaction(logic [7:0] b, logic err, logic [1:0] behind);
		int n_prior;
		int cnt;
		logic [7:0] c[4];
		n_prior = key_events.size();
		if (!raw_mode)
			return;
		case (parse_state)
			ST_ESC: begin
				parse_state = ST_IDLE;
				if (err)
					add_event(tksd_pkg::KIND_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
				else if (b != tksd_pkg::CH_LBRKT) begin
					add_event(tksd_pkg::KIND_REGULAR, tksd_pkg::CH_ESC, 8'h00, 8'h00, 8'h00);
					decode_fresh(b, 1'b0, behind);
				end else if (behind == 2'd0)
					add_event(tksd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00);
				else
					parse_state = ST_CSI;
			end
			ST_CSI: begin
				parse_state = ST_IDLE;
				if (err)
					add_event(tksd_pkg::KIND_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
				else begin
					case (b)
						CSI_UP:    add_event(tksd_pkg::KIND_UP, 8'h00, 8'h00, 8'h00, 8'h00);
						CSI_DOWN:  add_event(tksd_pkg::KIND_DOWN, 8'h00, 8'h00, 8'h00, 8'h00);
						CSI_RIGHT: add_event(tksd_pkg::KIND_RIGHT, 8'h00, 8'h00, 8'h00, 8'h00);
						CSI_LEFT:  add_event(tksd_pkg::KIND_LEFT, 8'h00, 8'h00, 8'h00, 8'h00);
						CSI_HOME:  add_event(tksd_pkg::KIND_HOME, 8'h00, 8'h00, 8'h00, 8'h00);
						CSI_END:   add_event(tksd_pkg::KIND_END, 8'h00, 8'h00, 8'h00, 8'h00);
						default: begin
							if (behind == 2'd0)
								add_event(tksd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00);
							else begin
								csi_param = b;
								parse_state = ST_CSI_PARAM;
							end
						end
					endcase
				end
			end
			ST_CSI_PARAM: begin
				parse_state = ST_IDLE;
				if (err)
					add_event(tksd_pkg::KIND_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
				else if (b != tksd_pkg::CH_TILDE)
					add_event(tksd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00);
				else begin
					case (csi_param)
						PARM_INS:  add_event(tksd_pkg::KIND_INSERT, 8'h00, 8'h00, 8'h00, 8'h00);
						PARM_DEL:  add_event(tksd_pkg::KIND_DELETE, 8'h00, 8'h00, 8'h00, 8'h00);
						PARM_PGUP: add_event(tksd_pkg::KIND_PGUP, 8'h00, 8'h00, 8'h00, 8'h00);
						PARM_PGDN: add_event(tksd_pkg::KIND_PGDN, 8'h00, 8'h00, 8'h00, 8'h00);
						default:   add_event(tksd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00);
					endcase
				end
			end
			ST_UTF8, ST_UTF8_BAD: begin
				if (err)
					parse_state = ST_UTF8_BAD;
				else if (utf8_count < 3'd3)
					utf8_buf[utf8_count] = b;
				utf8_count = utf8_count + 3'd1;
				cnt = int'(utf8_count);
				if (utf8_count >= utf8_need || cnt > 4 || cnt == 0) begin
					if (parse_state == ST_UTF8_BAD || cnt > 4 || cnt == 0)
						add_event(tksd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00);
					else begin
						for (int i = 0; i < 4; i++)
							c[i] = 8'h00;
						for (int i = 0; i + 1 < cnt && i < 3; i++)
							c[i] = utf8_buf[i];
						c[cnt - 1] = b;
						add_event(tksd_pkg::KIND_REGULAR, c[0], c[1], c[2], c[3]);
					end
					parse_state = ST_IDLE;
					utf8_buf = '{8'h00, 8'h00, 8'h00};
					utf8_need = 3'd0;
					utf8_count = 3'd0;
				end
			end
			default: decode_fresh(b, err, behind);
		endcase
		if (key_events.size() > n_prior)
			key_events[key_events.size() - 1].last = 1'b1;
	endfunction

	task automatic report(string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report($sformatf("%s of key event %0d: got %0h, expected %0h",
				name, events_seen, got, want));
	endtask

	task automatic check_key_event();
		tksd_pkg::result_t want;
		if (key_events.size() == 0) begin
			report($sformatf("key event %0d (kind %0d) with none pending", events_seen, key_kind));
		end else begin
			want = key_events.pop_front();
			check_field("key_kind", 8'(key_kind), 8'(want.kind));
			check_field("char_byte0", char_byte0, want.b0);
			check_field("char_byte1", char_byte1, want.b1);
			check_field("char_byte2", char_byte2, want.b2);
			check_field("char_byte3", char_byte3, want.b3);
			check_field("last_result", 8'(last_result), 8'(want.last));
		end
		events_seen++;
	endtask

	// key byte driver
	always @(posedge clk) begin
		key_input_t nxt;
		if (!arst_n)
			in_valid <= 1'b0;
		else begin
			if (in_valid && !in_stall)
				decode_transaction(key_byte, read_error, bytes_behind);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_keys.size() > 0) begin
					nxt = pending_keys.pop_front();
					key_byte <= nxt.b;
					read_error <= nxt.err;
					bytes_behind <= nxt.behind;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 7);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// key event monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_key_event();
		if (!arst_n)
			out_stall <= 1'b0;
		else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 6);
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** terminal_key_sequence_decoder_core: FAILED **");
			$finish;
		end
	end

	task automatic push_key(logic [7:0] b, logic err, logic [1:0] behind);
		key_input_t k;
		k.b = b;
		k.err = err;
		k.behind = behind;
		pending_keys.insert(pending_keys.size(), k);
		keys_queued++;
	endtask

	task automatic write_raw_mode(logic value);
		@(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		raw_mode = value;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_keys.size() != 0 || in_valid || key_events.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic queue_utf8();
		int n;
		int err_at;
		logic [7:0] lead;
		n = $urandom_range(2, 4);
		case (n)
			2: lead = {3'b110, 5'($urandom)};
			3: lead = {4'b1110, 4'($urandom)};
			default: lead = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hFF))
				: 8'($urandom_range(8'h80, 8'hBF));
		endcase
		if ($urandom_range(0, 9) == 0) begin
			push_key(lead, 1'b0, 2'($urandom_range(0, n - 2)));
			return;
		end
		err_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : 0;
		push_key(lead, 1'b0, 2'((n - 1 > 3) ? 3 : n - 1));
		for (int i = 1; i < n; i++)
			push_key(($urandom_range(0, 4) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)},
				i == err_at, 2'(n - 1 - i));
	endtask

	task automatic queue_random(int count);
		int start;
		int pick;
		logic [7:0] b;
		start = keys_queued;
		@(negedge clk);
		while (keys_queued - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				b = 8'($urandom_range(0, 8'h7F));
				if (b == tksd_pkg::CH_ESC)
					b = 8'h20;
				push_key(b, 1'b0, 2'($urandom));
			end else if (pick < 30) begin
				push_key(tksd_pkg::CH_ESC, 1'b0, 2'($urandom_range(2, 3)));
				push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'($urandom_range(1, 3)));
				push_key(arrow_keys[$urandom_range(0, 5)], 1'b0, 2'($urandom));
			end else if (pick < 40) begin
				push_key(tksd_pkg::CH_ESC, 1'b0, 2'd3);
				push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'($urandom_range(2, 3)));
				b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h30, 8'h39))
					: edit_params[$urandom_range(0, 3)];
				push_key(b, 1'b0, 2'($urandom_range(1, 3)));
				b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : tksd_pkg::CH_TILDE;
				push_key(b, 1'b0, 2'($urandom));
			end else if (pick < 60) begin
				queue_utf8();
			end else if (pick < 70) begin
				if ($urandom_range(0, 1))
					push_key(tksd_pkg::CH_ESC, 1'b0, 2'd0);
				else begin
					push_key(tksd_pkg::CH_ESC, 1'b0, 2'($urandom_range(1, 3)));
					push_key(8'($urandom), 1'b0, 2'($urandom));
				end
			end else if (pick < 80) begin
				push_key(tksd_pkg::CH_ESC, 1'b0, 2'($urandom_range(1, 3)));
				case ($urandom_range(0, 2))
					0: push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'd0);
					1: begin
						push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'($urandom_range(1, 3)));
						push_key(8'($urandom), $urandom_range(0, 3) == 0, 2'($urandom_range(0, 1)));
					end
					default: push_key(8'($urandom), 1'b1, 2'($urandom));
				endcase
			end else
				push_key(8'($urandom), $urandom_range(0, 7) == 0, 2'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_raw_mode(1'b1);
		@(negedge clk);
		push_key(8'h00, 1'b0, 2'd0);
		push_key(8'h7F, 1'b0, 2'd3);
		push_key(8'hFF, 1'b1, 2'd3);
		push_key(tksd_pkg::CH_ESC, 1'b0, 2'd0);
		push_key(tksd_pkg::CH_ESC, 1'b0, 2'd1);
		push_key(8'h51, 1'b0, 2'd0);
		push_key(tksd_pkg::CH_ESC, 1'b0, 2'd2);
		push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'd1);
		push_key(CSI_HOME, 1'b0, 2'd0);
		push_key(tksd_pkg::CH_ESC, 1'b0, 2'd1);
		push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'd0);
		push_key(tksd_pkg::CH_ESC, 1'b0, 2'd3);
		push_key(tksd_pkg::CH_LBRKT, 1'b0, 2'd2);
		push_key(PARM_PGDN, 1'b0, 2'd1);
		push_key(tksd_pkg::CH_TILDE, 1'b0, 2'd0);
		push_key(tksd_pkg::CH_ESC, 1'b0, 2'd1);
		push_key(8'h00, 1'b1, 2'd0);
		push_key(8'hF8, 1'b0, 2'd0);
		push_key(8'hF0, 1'b0, 2'd3);
		push_key(8'h9F, 1'b0, 2'd2);
		push_key(8'h98, 1'b1, 2'd1);
		push_key(8'h80, 1'b0, 2'd0);
		push_key(8'hE2, 1'b0, 2'd2);
		push_key(8'h82, 1'b0, 2'd1);
		push_key(8'hAC, 1'b0, 2'd0);
		wait_drained();

		queue_random(400);
		wait_drained();

		write_raw_mode(1'b0);
		queue_random(100);
		wait_drained();

		write_raw_mode(1'b1);
		queue_random(500);
		wait_drained();

		quiet = 1'b1;
		queue_random(250);
		wait_drained();

		if (key_events.size() != 0)
			report($sformatf("%0d key events never seen", key_events.size()));
		if (mismatches == 0)
			$display("** terminal_key_sequence_decoder_core: PASSED **");
		else
			$display("** terminal_key_sequence_decoder_core: FAILED **");
		$finish;
	end

endmodule

// ===== terminal_key_sequence_decoder_core.f =====
rtl/tksd_pkg.sv
rtl/terminal_key_sequence_decoder_core.sv
rtl/tksd_checker.sv
tb/sv/terminal_key_sequence_decoder_core_tb.sv
